### sv/mma_pkg.sv
// ----------------------------------------------------------------------------
// mma_pkg
// Shared types, constants and the data length lookup for the MIDI assembler.
// ----------------------------------------------------------------------------
package mma_pkg;

  localparam int unsigned ByteW   = 8;
  localparam int unsigned DataW   = 7;
  localparam int unsigned LenW    = 2;
  localparam int unsigned TableW  = 32;
  localparam int unsigned MsgW    = ByteW + 2 * DataW + LenW;
  localparam int unsigned TdataW  = ((MsgW + 7) / 8) * 8;

  // Counts: 2 for 8..B and E, 1 for C and D, 0 elsewhere
  localparam logic [TableW-1:0] TableReset = 32'h25AA_0000;

  localparam logic [LenW-1:0] LenStatusOnly = 2'd1;
  localparam logic [LenW-1:0] LenOneData    = 2'd2;
  localparam logic [LenW-1:0] LenTwoData    = 2'd3;

  typedef struct packed {
    logic [LenW-1:0]  length;
    logic [DataW-1:0] data2;
    logic [DataW-1:0] data1;
    logic [ByteW-1:0] status;
  } msg_t;

  // Data byte count for a status byte, saturated to two
  function automatic logic [1:0] data_count(input logic [TableW-1:0] tbl,
                                            input logic [ByteW-1:0]  st);
    logic [1:0] c;
    c = tbl[{st[7:4], 1'b0} +: 2];
    return (c == 2'd3) ? 2'd2 : c;
  endfunction

endpackage

### sv/mma_core.sv
// ----------------------------------------------------------------------------
// mma_core
// Input byte register, running status state and message assembly logic.
// ----------------------------------------------------------------------------
module mma_core
  import mma_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_wr_en,
  input  logic [TableW-1:0] cfg_wr_data,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [ByteW-1:0]  in_byte,
  output logic              res_valid,
  input  logic              res_ready,
  output msg_t              res
);

  logic [TableW-1:0] length_table;
  logic              byte_vld;
  logic [ByteW-1:0]  byte_q;
  logic [ByteW-1:0]  running_status;
  logic [1:0]        bytes_remaining;
  logic              data_seen;
  logic [DataW-1:0]  first_data;

  logic [ByteW-1:0]  running_status_next;
  logic [1:0]        bytes_remaining_next;
  logic              data_seen_next;
  logic [DataW-1:0]  first_data_next;
  logic              advance;

  always_comb begin
    logic [1:0]       cnt_new;
    logic [1:0]       cnt_run;
    logic [1:0]       rem0;
    logic [1:0]       rem1;
    logic             seen0;
    logic [DataW-1:0] fd0;
    logic [DataW-1:0] fd1;
    logic [DataW-1:0] d;

    d       = byte_q[DataW-1:0];
    cnt_new = data_count(length_table, byte_q);
    cnt_run = data_count(length_table, running_status);

    running_status_next  = running_status;
    bytes_remaining_next = bytes_remaining;
    data_seen_next       = data_seen;
    first_data_next      = first_data;
    res_valid            = 1'b0;
    res                  = '0;
    rem0 = bytes_remaining;
    seen0 = data_seen;
    fd0  = first_data;
    fd1  = first_data;
    rem1 = bytes_remaining;

    if (byte_q[ByteW-1]) begin
      // status byte: restart, drop any partial message
      running_status_next  = byte_q;
      bytes_remaining_next = cnt_new;
      data_seen_next       = 1'b0;
      first_data_next      = '0;
      if (cnt_new == 2'd0) begin
        res_valid  = byte_vld;
        res.status = byte_q;
        res.length = LenStatusOnly;
      end
    end else if (bytes_remaining != 2'd0 || cnt_run != 2'd0) begin
      if (bytes_remaining == 2'd0) begin
        // reuse running status
        rem0  = cnt_run;
        seen0 = 1'b0;
        fd0   = '0;
      end
      fd1  = seen0 ? fd0 : d;
      rem1 = rem0 - 2'd1;
      if (rem1 != 2'd0) begin
        bytes_remaining_next = rem1;
        data_seen_next       = 1'b1;
        first_data_next      = fd1;
      end else begin
        bytes_remaining_next = 2'd0;
        data_seen_next       = 1'b0;
        first_data_next      = '0;
        res_valid            = byte_vld;
        res.status           = running_status;
        if (seen0) begin
          res.data1  = fd1;
          res.data2  = d;
          res.length = LenTwoData;
        end else begin
          res.data1  = d;
          res.length = LenOneData;
        end
      end
    end

    advance  = byte_vld && (!res_valid || res_ready);
    in_ready = !byte_vld || advance;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      length_table    <= TableReset;
      byte_vld        <= 1'b0;
      running_status  <= '0;
      bytes_remaining <= '0;
      data_seen       <= 1'b0;
      first_data      <= '0;
    end else begin
      if (cfg_wr_en) begin
        length_table <= cfg_wr_data;
      end
      if (in_ready) begin
        byte_vld <= in_valid;
      end
      if (advance) begin
        running_status  <= running_status_next;
        bytes_remaining <= bytes_remaining_next;
        data_seen       <= data_seen_next;
        first_data      <= first_data_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      byte_q <= in_byte;
    end
  end

endmodule

### sv/mma_out.sv
// ----------------------------------------------------------------------------
// mma_out
// Result register toward the downstream stream port.
// ----------------------------------------------------------------------------
module mma_out
  import mma_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              res_valid,
  output logic              res_ready,
  input  msg_t              res,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [TdataW-1:0] out_data
);

  msg_t msg_q;

  assign res_ready = !out_valid || out_ready;
  assign out_data  = TdataW'(msg_q);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_ready) begin
      out_valid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      msg_q <= res;
    end
  end

endmodule

### sv/midi_message_assembler.sv
// ----------------------------------------------------------------------------
// midi_message_assembler
// Turns a raw MIDI byte stream into complete messages with explicit status.
// ----------------------------------------------------------------------------
// One byte is taken per cycle when the downstream side keeps up; a byte
// passes through an input register and the assembly logic into the result
// register, from which the completed message is presented downstream.
// Status bytes set the running status and load the data byte count from
// cfg_wr_data's table (two bits per status high nibble, a count of 3 acts
// as 2); data bytes with no message open reuse the running status. Write
// the table only while the block is idle.
module midi_message_assembler
  import mma_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_wr_en,
  input  logic [TableW-1:0] cfg_wr_data,
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  input  logic [ByteW-1:0]  s_axis_tdata,   // [7:0] in_byte
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  output logic [TdataW-1:0] m_axis_tdata    // [7:0] msg_status, [14:8] msg_data1,
                                            // [21:15] msg_data2, [23:22] msg_length
);

  logic res_valid;
  logic res_ready;
  msg_t res;

  mma_core u_core (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_valid    (s_axis_tvalid),
    .in_ready    (s_axis_tready),
    .in_byte     (s_axis_tdata),
    .res_valid   (res_valid),
    .res_ready   (res_ready),
    .res         (res)
  );

  mma_out u_out (
    .clk       (clk),
    .rst       (rst),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_data  (m_axis_tdata)
  );

  a_ready_when_empty : assert property (@(posedge clk) disable iff (rst)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled with empty result register");

  a_length_nonzero : assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> m_axis_tdata[23:22] != 2'd0)
    else $error("result with zero length");

  a_absent_data_zero : assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tdata[23:22] == LenStatusOnly) |->
      (m_axis_tdata[21:8] == 14'd0))
    else $error("status-only message carries data");

  a_one_data_zero : assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tdata[23:22] == LenOneData) |->
      (m_axis_tdata[21:15] == 7'd0))
    else $error("one-data message carries second data byte");

endmodule
